[hdl/oad_pkg.sv]
// Package: constants, command codes and beat types for the Allan deviation block
`default_nettype none
package oad_pkg;

    localparam int MAX_SAMPLES = 131072;
    localparam int MAX_CLUSTER = 32769;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int INT_W       = 34;
    localparam int ABS_W       = 32;
    localparam int SQ_W        = 2 * ABS_W;
    localparam int ACC_W       = SQ_W + CNT_W - 1;
    localparam int NUM_W       = ACC_W + 16;
    localparam int MM_W        = 31;
    localparam int DEN_W       = MM_W + CNT_W;
    localparam int REM_W       = DEN_W + 1;
    localparam int VAR_W       = 48;
    localparam int DEV_W       = 32;
    localparam int ROOT_W      = 64;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_SPARE   = 2'd3;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_BAD = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] sample;
        logic [15:0]        cluster_len;
    } cmd_t;

    typedef struct packed {
        logic [15:0]      echo_len;
        logic [VAR_W-1:0] variance;
        logic [DEV_W-1:0] deviation;
        logic             status;
    } result_t;

endpackage
`default_nettype wire

[hdl/overlapping_allan_deviation.sv]
// Top level: integral store, second-difference walk, divider and square root
//
//  channel   signals               handshake
//  command   start, busy, cmd      beat taken when start is high and busy is low
//  result    done, result          beat valid for the one cycle done is high
//
// A load or restart leaves busy low. A query that is out of range answers in the
// next cycle without raising busy. A valid query walks the store with one read
// port, three reads per position, then drains the pipeline, forms the denominator,
// runs a restoring division and takes the square root; busy falls as done rises.
// Reset clears the sample count and the running integral; the store is not cleared.
`default_nettype none
module overlapping_allan_deviation (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire oad_pkg::cmd_t    cmd,
    output logic                  done,
    output oad_pkg::result_t      result
);
    import oad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_WALK, S_DRAIN, S_DEN1, S_DEN2, S_DIV, S_SQRT
    } state_t;

    logic [INT_W-1:0] mem [MAX_SAMPLES];

    state_t            state_reg;
    logic [INT_W-1:0]  ri_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [15:0]       m_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [ADDR_W-1:0] k_reg;
    logic [1:0]        ph_reg;
    logic              rd_vld_reg;
    logic [1:0]        rd_tag_reg;
    logic [INT_W-1:0]  rd_q_reg;
    logic [INT_W-1:0]  t_reg;
    logic [ABS_W-1:0]  a_reg;
    logic              a_vld_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic              sq_vld_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [MM_W-1:0]   mm_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [VAR_W-1:0]  q_reg;
    logic              ovf_reg;
    logic [6:0]        it_reg;
    logic [ROOT_W-1:0] x_reg;
    logic [ROOT_W-1:0] res_reg;
    logic [ROOT_W-1:0] bit_reg;
    logic              done_reg;
    result_t           result_reg;

    logic              wr_en;
    logic [INT_W-1:0]  ri_next;
    logic [ADDR_W-1:0] rd_addr;
    logic [INT_W-1:0]  dsum;
    logic [INT_W-1:0]  dabs;
    logic [REM_W-1:0]  rem_next;
    logic              qbit;
    logic [VAR_W-1:0]  var_next;
    logic [ROOT_W-1:0] trial;
    logic [ROOT_W-1:0] res_next;
    logic              bad_query;
    logic [CNT_W-1:0]  two_m;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        ri_next   = ri_reg + {{(INT_W-16){cmd.sample[15]}}, cmd.sample};
        wr_en     = start && !busy && cmd.op == OP_LOAD && cnt_reg < CNT_W'(MAX_SAMPLES);
        two_m     = CNT_W'({cmd.cluster_len, 1'b0});
        bad_query = cmd.cluster_len == 16'd0
                 || {1'b0, cmd.cluster_len} > 17'(MAX_CLUSTER)
                 || two_m >= cnt_reg;
        case (ph_reg)
            2'd1:    rd_addr = k_reg + ADDR_W'(m_reg);
            2'd2:    rd_addr = k_reg + ADDR_W'({m_reg, 1'b0});
            default: rd_addr = k_reg;
        endcase
        dsum     = t_reg + rd_q_reg;
        dabs     = dsum[INT_W-1] ? (~dsum + INT_W'(1)) : dsum;
        rem_next = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
        qbit     = rem_next >= {1'b0, den_reg};
        var_next = ovf_reg ? {VAR_W{1'b1}} : q_reg;
        trial    = res_reg + bit_reg;
        res_next = (x_reg >= trial) ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
    end

    // store: one write port for loads, one registered read port for the walk
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[ADDR_W-1:0]] <= ri_next;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ri_reg     <= '0;
            cnt_reg    <= '0;
            ph_reg     <= '0;
            rd_vld_reg <= 1'b0;
            rd_tag_reg <= '0;
            a_vld_reg  <= 1'b0;
            sq_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
            sq_vld_reg <= a_vld_reg;

            // second-difference pipeline: s0, then -2*s1, then +s2
            if (rd_vld_reg)
            begin
                case (rd_tag_reg)
                    2'd0:    t_reg <= rd_q_reg;
                    2'd1:    t_reg <= t_reg - {rd_q_reg[INT_W-2:0], 1'b0};
                    default:
                    begin
                        a_reg     <= dabs[ABS_W-1:0];
                        a_vld_reg <= 1'b1;
                    end
                endcase
            end
            if (a_vld_reg)
            begin
                sq_reg <= a_reg * a_reg;
            end
            if (sq_vld_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(sq_reg);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        unique case (cmd.op)
                            OP_LOAD:
                            begin
                                if (wr_en)
                                begin
                                    ri_reg  <= ri_next;
                                    cnt_reg <= cnt_reg + CNT_W'(1);
                                end
                            end
                            OP_QUERY:
                            begin
                                m_reg   <= cmd.cluster_len;
                                n_reg   <= cnt_reg - two_m;
                                k_reg   <= '0;
                                ph_reg  <= '0;
                                acc_reg <= '0;
                                if (bad_query)
                                begin
                                    done_reg            <= 1'b1;
                                    result_reg.echo_len <= cmd.cluster_len;
                                    result_reg.variance <= '0;
                                    result_reg.deviation <= '0;
                                    result_reg.status   <= ST_BAD;
                                end
                                else
                                begin
                                    state_reg <= S_WALK;
                                end
                            end
                            OP_RESTART:
                            begin
                                ri_reg  <= '0;
                                cnt_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_WALK:
                begin
                    rd_vld_reg <= 1'b1;
                    rd_tag_reg <= ph_reg;
                    if (ph_reg == 2'd2)
                    begin
                        ph_reg <= '0;
                        if ({1'b0, k_reg} == n_reg - CNT_W'(1))
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            k_reg <= k_reg + ADDR_W'(1);
                        end
                    end
                    else
                    begin
                        ph_reg <= ph_reg + 2'd1;
                    end
                end
                S_DRAIN:
                begin
                    if (!rd_vld_reg && !a_vld_reg && !sq_vld_reg)
                    begin
                        state_reg <= S_DEN1;
                    end
                end
                S_DEN1:
                begin
                    mm_reg    <= MM_W'(m_reg) * MM_W'(m_reg);
                    num_reg   <= {acc_reg, 16'd0};
                    state_reg <= S_DEN2;
                end
                S_DEN2:
                begin
                    den_reg   <= (DEN_W'(mm_reg) * DEN_W'(n_reg)) << 1;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    ovf_reg   <= 1'b0;
                    it_reg    <= 7'(NUM_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= qbit ? (rem_next - {1'b0, den_reg}) : rem_next;
                    num_reg <= num_reg << 1;
                    q_reg   <= {q_reg[VAR_W-2:0], qbit};
                    ovf_reg <= ovf_reg | q_reg[VAR_W-1];
                    if (it_reg == 7'd0)
                    begin
                        state_reg <= S_SQRT;
                    end
                    else
                    begin
                        it_reg <= it_reg - 7'd1;
                    end
                end
                S_SQRT:
                begin
                    if (it_reg == 7'd0 && bit_reg == '0)
                    begin
                        // first cycle after division: load the radicand
                        x_reg   <= {var_next, 16'd0};
                        res_reg <= '0;
                        bit_reg <= ROOT_W'(1) << (ROOT_W - 2);
                        it_reg  <= 7'd1;
                    end
                    else
                    begin
                        if (x_reg >= trial)
                        begin
                            x_reg <= x_reg - trial;
                        end
                        res_reg <= res_next;
                        bit_reg <= bit_reg >> 2;
                        if (bit_reg[0])
                        begin
                            it_reg               <= 7'd0;
                            done_reg             <= 1'b1;
                            result_reg.echo_len  <= m_reg;
                            result_reg.variance  <= var_next;
                            result_reg.deviation <= res_next[DEV_W-1:0];
                            result_reg.status    <= ST_OK;
                            state_reg            <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[tb/sv/oad_checker.sv]
// Checker for the Allan deviation block: predicts query answers and compares result beats
module oad_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire oad_pkg::cmd_t    cmd,
    input  wire logic             done,
    input  wire oad_pkg::result_t result,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import oad_pkg::*;

    logic [INT_W-1:0] integ_mem [MAX_SAMPLES];
    logic [INT_W-1:0] integ_acc;
    int unsigned      n_loaded;
    result_t          answers_due [$];

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic result_t allan_answer(input logic [15:0] m);
        result_t          r;
        logic [127:0]     acc;
        logic [127:0]     quot;
        logic [INT_W-1:0] d;
        logic [31:0]      mag;
        logic [63:0]      den;
        int unsigned      span;
        r.echo_len  = m;
        r.variance  = '0;
        r.deviation = '0;
        r.status    = ST_BAD;
        if (m == 0 || m > MAX_CLUSTER || 2 * int'(m) >= n_loaded)
            return r;
        span = n_loaded - 2 * m;
        acc  = '0;
        for (int unsigned k = 0; k < span; k++)
        begin
            d   = integ_mem[k + 2 * m] - (integ_mem[k + m] << 1) + integ_mem[k];
            mag = d[INT_W-1] ? 32'(-d) : 32'(d);
            acc += 128'(64'(mag) * 64'(mag));
        end
        den  = 64'(2) * m * m * span;
        quot = (acc << 16) / 128'(den);
        r.variance  = (quot > 128'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : quot[VAR_W-1:0];
        r.deviation = DEV_W'(isqrt(64'(r.variance) << 16));
        r.status    = ST_OK;
        return r;
    endfunction

    task automatic report(input string what);
        $display("%0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            integ_acc = '0;
            n_loaded  = 0;
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                    report($sformatf("unexpected result beat, len %0d", result.echo_len));
                else
                begin
                    want = answers_due.pop_front();
                    if (result.echo_len !== want.echo_len)
                        report($sformatf("echo_len %0d, want %0d", result.echo_len,
                                         want.echo_len));
                    if (result.variance !== want.variance)
                        report($sformatf("variance %0h, want %0h (m %0d)", result.variance,
                                         want.variance, want.echo_len));
                    if (result.deviation !== want.deviation)
                        report($sformatf("deviation %0h, want %0h (m %0d)", result.deviation,
                                         want.deviation, want.echo_len));
                    if (result.status !== want.status)
                        report($sformatf("status %0b, want %0b (m %0d)", result.status,
                                         want.status, want.echo_len));
                end
            end
            if (start && !busy)
            begin
                case (cmd.op)
                    OP_LOAD:
                        if (n_loaded < MAX_SAMPLES)
                        begin
                            integ_acc = integ_acc + INT_W'(cmd.sample);
                            integ_mem[n_loaded] = integ_acc;
                            n_loaded++;
                        end
                    OP_RESTART:
                    begin
                        integ_acc = '0;
                        n_loaded  = 0;
                    end
                    OP_QUERY:
                        answers_due = {answers_due, allan_answer(cmd.cluster_len)};
                    default: ;
                endcase
            end
            pending = answers_due.size();
        end
    end
endmodule

[tb/sv/tb_overlapping_allan_deviation.sv]
// Testbench top: clock, reset, command stimulus and the verdict
module tb_overlapping_allan_deviation;
    timeunit 1ns;
    timeprecision 1ps;
    import oad_pkg::*;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;
    int      fail_count;
    int      pending;
    int      idle_pct;

    overlapping_allan_deviation i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    oad_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hold the command until a beat is taken; drop start only while idling
    task automatic send(input logic [1:0] op, input logic [15:0] smp, input logic [15:0] len);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{op: op, sample: smp, cluster_len: len};
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic load_block(input int n, input int kind);
        logic [15:0] s;
        for (int i = 0; i < n; i++)
        begin
            case (kind)
                0: s = 16'h7fff;
                1: s = 16'h8000;
                2: s = (i % 2) ? 16'h7fff : 16'h8000;
                default: s = 16'($urandom);
            endcase
            send(OP_LOAD, s, 16'($urandom));
        end
    endtask

    initial
    begin
        int len;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = '0;
        idle_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, bad lengths, extreme samples, unused op
        send(OP_QUERY, 16'($urandom), 16'd1);
        send(OP_QUERY, 16'($urandom), 16'd0);
        load_block(5, 0);
        send(OP_QUERY, 16'($urandom), 16'd2);
        send(OP_QUERY, 16'($urandom), 16'd3);
        send(OP_QUERY, 16'($urandom), 16'd1);
        send(OP_RESTART, 16'($urandom), 16'($urandom));
        load_block(7, 1);
        send(OP_SPARE, 16'($urandom), 16'($urandom));
        send(OP_QUERY, 16'($urandom), 16'd1);
        send(OP_QUERY, 16'($urandom), 16'd32770);
        send(OP_QUERY, 16'($urandom), 16'hffff);
        send(OP_RESTART, 16'($urandom), 16'($urandom));
        load_block(9, 2);
        send(OP_QUERY, 16'($urandom), 16'd1);
        send(OP_QUERY, 16'($urandom), 16'd4);
        send(OP_RESTART, 16'($urandom), 16'($urandom));

        // random: short loaded runs then queries, across three idle patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 37 : (phase == 1) ? 70 : 0;
            for (int grp = 0; grp < 2; grp++)
            begin
                len = $urandom_range(4, 12);
                load_block(len, $urandom_range(0, 5));
                repeat ($urandom_range(1, 3))
                    send(OP_QUERY, 16'($urandom),
                         ($urandom_range(9) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(1, len / 2 + 1)));
                if ($urandom_range(3) == 0)
                    send(OP_SPARE, 16'($urandom), 16'($urandom));
                send(OP_RESTART, 16'($urandom), 16'($urandom));
            end
        end
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #200us;
        $display("Mismatches found");
        $finish;
    end
endmodule
